// ===== hw/rtl/bicc_pkg.sv =====
// bicc_pkg: shared types and constants for the binary image corner counter
// no dependencies; imported by bicc_accum and binary_image_corner_count
`default_nettype none

package bicc_pkg;

    localparam int CFG_W   = 11;
    localparam int COUNT_W = 22;

    localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd1024;

    typedef struct packed {
        logic pixel_bit;
        logic last_pixel;
    } pixel_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] corner_count;
        logic               last;
    } result_beat_t;

    // window control passed from the scan stage to the accumulate stage
    typedef struct packed {
        logic pixel;
        logic last;
        logic past_first_row;
        logic col_nonzero;
        logic row_wrap;
    } stage_info_t;

endpackage : bicc_pkg

`default_nettype wire

// ===== hw/rtl/bicc_line_buf.sv =====
// bicc_line_buf: one-bit-wide line buffer with a registered, synchronous read
// forwards a write that hits the address being read in the same cycle
`default_nettype none

module bicc_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_data,
    output logic                   rd_data
);

    logic mem [DEPTH];
    logic q_reg;
    logic fwd_reg;
    logic fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule : bicc_line_buf

`default_nettype wire

// ===== hw/rtl/bicc_accum.sv =====
// bicc_accum: 2x2 window scoring and saturating running total
// depends on bicc_pkg for stage_info_t and the count width
`default_nettype none

module bicc_accum #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire bicc_pkg::stage_info_t      info,
    input  wire logic                       up_raw,
    output logic                            up_bit,
    output logic [bicc_pkg::COUNT_W-1:0]    count_next
);

    import bicc_pkg::*;

    localparam longint FULL_LIMIT = 4 * longint'(MAX_COLUMNS - 1) * longint'(MAX_ROWS - 1);
    localparam longint CAP        = (longint'(1) << COUNT_W) - 1;
    localparam logic [COUNT_W:0] LIMIT =
        (COUNT_W + 1)'((FULL_LIMIT > CAP) ? CAP : FULL_LIMIT);

    logic               left_reg;
    logic               upper_left_reg;
    logic [COUNT_W-1:0] total_reg;

    logic               left_next;
    logic               upper_left_next;
    logic [COUNT_W-1:0] total_next;
    logic [2:0]         ones;
    logic [2:0]         add;
    logic [COUNT_W:0]   sum;

    always_comb
    begin
        up_bit = info.past_first_row & up_raw;
        ones   = 3'(upper_left_reg) + 3'(up_bit) + 3'(left_reg) + 3'(info.pixel);
        case (ones)
            3'd4:    add = 3'd4;
            3'd3:    add = 3'd1;
            default: add = 3'd0;
        endcase
        sum = {1'b0, total_reg} + (COUNT_W + 1)'(add);
        if (info.past_first_row && info.col_nonzero)
        begin
            count_next = (sum > LIMIT) ? LIMIT[COUNT_W-1:0] : sum[COUNT_W-1:0];
        end
        else
        begin
            count_next = total_reg;
        end

        if (info.last)
        begin
            left_next       = 1'b0;
            upper_left_next = 1'b0;
            total_next      = '0;
        end
        else
        begin
            left_next       = info.row_wrap ? 1'b0 : info.pixel;
            upper_left_next = info.row_wrap ? 1'b0 : up_bit;
            total_next      = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= 1'b0;
            upper_left_reg <= 1'b0;
            total_reg      <= '0;
        end
        else if (en)
        begin
            left_reg       <= left_next;
            upper_left_reg <= upper_left_next;
            total_reg      <= total_next;
        end
    end

endmodule : bicc_accum

`default_nettype wire

// ===== hw/rtl/binary_image_corner_count.sv =====
// binary_image_corner_count: top level, scan stage, line buffer, accumulator, output register
// depends on bicc_pkg, bicc_line_buf and bicc_accum
//
// usage
// - in channel: one pixel beat per cycle while in_ready is high, in raster order, pixel_bit and last_pixel
// - cfg channel: writes image_columns (pixels per row); always ready, write only when idle
// - out channel: one beat per image, sent on the beat flagged last_pixel, carrying
//   the corner total (saturating) and last = 1
// - throughput: one pixel per cycle unless stalled as below; the line buffer is read in the scan
//   stage and written back by the accumulate stage, a same-address hit is forwarded
// - a last pixel passes the accumulate stage register, then its result is loaded into
//   the output register, which raises out_valid
// - the output register holds one result; pixels keep flowing while it waits, and
//   only a following last pixel stalls in the accumulate stage, dropping in_ready
//   until out_ready takes the pending result
// - reset: image_columns returns to 1024, row position and total clear, no result
//   pending; the line buffer is not cleared, its output is masked on the first row
// - image_columns of 0 acts as 1, above MAX_COLUMNS acts as MAX_COLUMNS
`default_nettype none

module binary_image_corner_count #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire bicc_pkg::pixel_beat_t     in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output bicc_pkg::result_beat_t         out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bicc_pkg::CFG_W-1:0] cfg_data
);

    import bicc_pkg::*;

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int EW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;
    localparam logic [EW-1:0] MAX_COLS_E = EW'(MAX_COLUMNS);

    logic [CFG_W-1:0] columns_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic             past_reg;
    logic             past_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    stage_info_t      s1_info_reg;
    stage_info_t      s0_info;
    logic [CW-1:0]    s1_addr_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    result_beat_t     out_data_reg;

    logic [EW-1:0]    cols_eff;
    logic [EW-1:0]    cfg_ext;
    logic [EW-1:0]    col_inc;
    logic             accept;
    logic             s1_stall;
    logic             s1_fire;
    logic             up_raw;
    logic             up_bit;
    logic [COUNT_W-1:0] count_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
        end
        else if (cfg_valid)
        begin
            columns_reg <= cfg_data;
        end
    end

    // handshake
    assign s1_stall = s1_valid_reg && s1_info_reg.last && out_valid_reg && !out_ready;
    assign s1_fire  = s1_valid_reg && !s1_stall;
    assign in_ready = !s1_stall;
    assign accept   = in_valid && in_ready;

    // scan stage
    always_comb
    begin
        cfg_ext = EW'(columns_reg);
        if (cfg_ext == '0)
        begin
            cols_eff = EW'(1);
        end
        else if (cfg_ext > MAX_COLS_E)
        begin
            cols_eff = MAX_COLS_E;
        end
        else
        begin
            cols_eff = cfg_ext;
        end
        col_inc = EW'(col_reg) + EW'(1);

        s0_info.pixel          = in_data.pixel_bit;
        s0_info.last           = in_data.last_pixel;
        s0_info.past_first_row = past_reg;
        s0_info.col_nonzero    = (col_reg != '0);
        s0_info.row_wrap       = (col_inc >= cols_eff);

        if (in_data.last_pixel)
        begin
            col_next  = '0;
            past_next = 1'b0;
        end
        else if (s0_info.row_wrap)
        begin
            col_next  = '0;
            past_next = 1'b1;
        end
        else
        begin
            col_next  = col_inc[CW-1:0];
            past_next = past_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            past_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            past_reg <= past_next;
        end
    end

    // accumulate stage
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= s0_info;
            s1_addr_reg <= col_reg;
        end
    end

    bicc_line_buf #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (CW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_info_reg.pixel),
        .rd_data (up_raw)
    );

    bicc_accum #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_fire),
        .info       (s1_info_reg),
        .up_raw     (up_raw),
        .up_bit     (up_bit),
        .count_next (count_next)
    );

    // output register
    always_comb
    begin
        if (s1_fire && s1_info_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_info_reg.last)
        begin
            out_data_reg.corner_count <= count_next;
            out_data_reg.last         <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_info_reg.last |=> out_valid_reg)
        else $error("last pixel did not load a result");

    a_last_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_pixel |=> (col_reg == '0) && !past_reg)
        else $error("scan state not cleared after last pixel");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_info_reg.last && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted while accumulate stage is stalled");

    a_first_row_no_up: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_info_reg.past_first_row |-> !up_bit)
        else $error("upper pixel used on the first row");

endmodule : binary_image_corner_count

`default_nettype wire
